[rtl/r2q_pkg.sv]
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared types, widths and helpers for the rotation-matrix-to-quaternion core.
// ----------------------------------------------------------------------------
package r2q_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int QUAT_W    = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int LIM       = (ONE < 32767) ? ONE : 32767;

  // Root argument: one plus three entries, signed.
  localparam int BASE_W    = (IN_W > FRAC_BITS + 1) ? IN_W : FRAC_BITS + 2;
  localparam int ARG_W     = BASE_W + 3;
  localparam int ARG_MAG_W = ARG_W - 1;

  // Square root of arg << FRAC_BITS.
  localparam int SQ_RAW_W  = ARG_MAG_W + FRAC_BITS;
  localparam int SQ_IN_W   = SQ_RAW_W + (SQ_RAW_W % 2);
  localparam int ROOT_W    = SQ_IN_W / 2;
  localparam int REM_W     = ROOT_W + 2;

  // Off-diagonal division: (|D| << FRAC_BITS + R) / (2R).
  localparam int MAG_W     = IN_W + 1;
  localparam int NUM_W     = ((MAG_W + FRAC_BITS) > ROOT_W ? (MAG_W + FRAC_BITS) : ROOT_W) + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int Q_W       = NUM_W;

  localparam int LANES     = 3;

  typedef logic signed [ARG_W-1:0]  arg_t;
  typedef logic signed [QUAT_W-1:0] quat_t;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [IN_W-1:0] rot00;
    logic signed [IN_W-1:0] rot01;
    logic signed [IN_W-1:0] rot02;
    logic signed [IN_W-1:0] rot10;
    logic signed [IN_W-1:0] rot11;
    logic signed [IN_W-1:0] rot12;
    logic signed [IN_W-1:0] rot20;
    logic signed [IN_W-1:0] rot21;
    logic signed [IN_W-1:0] rot22;
  } in_word_t;

  typedef struct packed {
    quat_t   quat_w;
    quat_t   quat_x;
    quat_t   quat_y;
    quat_t   quat_z;
    branch_t branch_taken;
    logic    bad_matrix;
  } out_word_t;

  // Sideband carried alongside the square root.
  typedef struct packed {
    branch_t                       branch;
    logic                          bad;
    logic [LANES-1:0]              d_neg;
    logic [LANES-1:0][MAG_W-1:0]   d_mag;
  } sq_side_t;

  // Sideband carried alongside the dividers.
  typedef struct packed {
    branch_t          branch;
    logic             bad;
    logic [ROOT_W-1:0] diag;
    logic [LANES-1:0] d_neg;
  } div_side_t;

  function automatic arg_t sx(logic signed [IN_W-1:0] v);
    return arg_t'(v);
  endfunction

  // Clamp a magnitude to LIM and apply the sign.
  function automatic quat_t sat_mag(logic [Q_W-1:0] m, logic neg);
    logic [Q_W-1:0] v;
    quat_t          r;
    v = (m > Q_W'(LIM)) ? Q_W'(LIM) : m;
    r = signed'(v[QUAT_W-1:0]);
    return neg ? -r : r;
  endfunction

endpackage

[rtl/rotation_matrix_to_quaternion_core.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a 3x3 rotation matrix in signed Q2.14 to a unit quaternion
// (Shepperd's method), fully pipelined.
// ----------------------------------------------------------------------------
// A new matrix word is taken on every clock where start is high; busy is
// always low. The result word appears on result with done high for exactly
// one cycle, and results leave in the same order the matrices came in. The
// receiver cannot stall, so it must capture every done cycle. The pipeline
// holds bit-serial arithmetic: 2 front stages (trace, compare, branch
// select), 16 square-root stages (one root bit each), 1 divider setup stage,
// 32 divider stages (one quotient bit each, three dividers side by side) and
// 1 output stage for saturation and reassembly. A non-rotation whose root
// argument is not positive gives a zero quaternion with bad_matrix set;
// branch_taken still reports the branch.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  r2q_pkg::in_word_t   operand,
  output logic                done,
  output r2q_pkg::out_word_t  result
);

  // The pipeline never stalls, so every start is taken.
  assign busy = 1'b0;

  // Front: branch pick, root argument and off-diagonal terms.
  logic                           fr_valid;
  logic [r2q_pkg::ARG_MAG_W-1:0]  fr_arg;
  r2q_pkg::sq_side_t              fr_side;

  r2q_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_word   (operand),
    .out_valid (fr_valid),
    .arg_mag   (fr_arg),
    .side      (fr_side)
  );

  // Square root of the argument scaled by 2^FRAC_BITS.
  logic                           sq_valid;
  logic [r2q_pkg::ROOT_W-1:0]     sq_root;
  r2q_pkg::sq_side_t              sq_side;

  r2q_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .arg_mag   (fr_arg),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Off-diagonal components, one divider per lane.
  logic                                         dv_valid;
  logic [r2q_pkg::LANES-1:0][r2q_pkg::Q_W-1:0]  dv_quot;
  r2q_pkg::div_side_t                           dv_side;

  r2q_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .root      (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .out_side  (dv_side)
  );

  // Output stage: saturate each lane, drop the branch component into its
  // slot, zero the quaternion on a bad matrix.
  r2q_pkg::quat_t     lane [r2q_pkg::LANES];
  r2q_pkg::quat_t     dg;
  r2q_pkg::out_word_t result_next;

  always_comb begin
    for (int k = 0; k < r2q_pkg::LANES; k++) begin
      lane[k] = r2q_pkg::sat_mag(dv_quot[k], dv_side.d_neg[k]);
    end
    dg = r2q_pkg::sat_mag(r2q_pkg::Q_W'(dv_side.diag), 1'b0);

    result_next.branch_taken = dv_side.branch;
    result_next.bad_matrix   = dv_side.bad;
    case (dv_side.branch)
      r2q_pkg::BR_TRACE: begin
        result_next.quat_w = dg;      result_next.quat_x = lane[0];
        result_next.quat_y = lane[1]; result_next.quat_z = lane[2];
      end
      r2q_pkg::BR_X: begin
        result_next.quat_w = lane[0]; result_next.quat_x = dg;
        result_next.quat_y = lane[1]; result_next.quat_z = lane[2];
      end
      r2q_pkg::BR_Y: begin
        result_next.quat_w = lane[0]; result_next.quat_x = lane[1];
        result_next.quat_y = dg;      result_next.quat_z = lane[2];
      end
      default: begin
        result_next.quat_w = lane[0]; result_next.quat_x = lane[1];
        result_next.quat_y = lane[2]; result_next.quat_z = dg;
      end
    endcase

    if (dv_side.bad) begin
      result_next.quat_w = '0;
      result_next.quat_x = '0;
      result_next.quat_y = '0;
      result_next.quat_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_valid;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // A bad matrix always reports a zero quaternion.
  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    done && result.bad_matrix |->
      result.quat_w == '0 && result.quat_x == '0 &&
      result.quat_y == '0 && result.quat_z == '0)
    else $error("bad matrix with nonzero quaternion");

  // The trace branch always has a positive root argument.
  a_trace_ok : assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.bad_matrix && result.branch_taken == r2q_pkg::BR_TRACE))
    else $error("trace branch flagged bad");

  // The branch component of a good matrix is never negative.
  a_diag_pos : assert property (@(posedge clk) disable iff (rst)
    dv_valid && !dv_side.bad |=> !result.bad_matrix && !(
      (result.branch_taken == r2q_pkg::BR_TRACE && result.quat_w < 0) ||
      (result.branch_taken == r2q_pkg::BR_X     && result.quat_x < 0) ||
      (result.branch_taken == r2q_pkg::BR_Y     && result.quat_y < 0) ||
      (result.branch_taken == r2q_pkg::BR_Z     && result.quat_z < 0)))
    else $error("branch component negative");

endmodule

[rtl/r2q_front.sv]
// ----------------------------------------------------------------------------
// r2q_front
// Two stages: form trace, candidate root arguments and off-diagonal terms,
// then pick the branch and route the three off-diagonal terms to lanes.
// ----------------------------------------------------------------------------
module r2q_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  r2q_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  output logic [r2q_pkg::ARG_MAG_W-1:0]     arg_mag,
  output r2q_pkg::sq_side_t                 side
);

  logic           v1;
  r2q_pkg::arg_t  trace;
  logic           gt_01, gt_02, gt_12;
  r2q_pkg::arg_t  arg_c [4];
  r2q_pkg::arg_t  d21m12, d02m20, d10m01, s01p10, s02p20, s12p21;

  r2q_pkg::arg_t  m00, m01, m02, m10, m11, m12, m20, m21, m22;
  r2q_pkg::arg_t  one_a;

  assign m00   = r2q_pkg::sx(in_word.rot00);
  assign m01   = r2q_pkg::sx(in_word.rot01);
  assign m02   = r2q_pkg::sx(in_word.rot02);
  assign m10   = r2q_pkg::sx(in_word.rot10);
  assign m11   = r2q_pkg::sx(in_word.rot11);
  assign m12   = r2q_pkg::sx(in_word.rot12);
  assign m20   = r2q_pkg::sx(in_word.rot20);
  assign m21   = r2q_pkg::sx(in_word.rot21);
  assign m22   = r2q_pkg::sx(in_word.rot22);
  assign one_a = r2q_pkg::arg_t'(r2q_pkg::ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    trace    <= m00 + m11 + m22;
    gt_01    <= m00 > m11;
    gt_02    <= m00 > m22;
    gt_12    <= m11 > m22;
    arg_c[0] <= m00 + m11 + m22 + one_a;
    arg_c[1] <= one_a + m00 - m11 - m22;
    arg_c[2] <= one_a + m11 - m00 - m22;
    arg_c[3] <= one_a + m22 - m00 - m11;
    d21m12   <= m21 - m12;
    d02m20   <= m02 - m20;
    d10m01   <= m10 - m01;
    s01p10   <= m01 + m10;
    s02p20   <= m02 + m20;
    s12p21   <= m12 + m21;
  end

  r2q_pkg::branch_t br;
  r2q_pkg::arg_t    arg;
  r2q_pkg::arg_t    d_sel [r2q_pkg::LANES];
  logic             bad;
  r2q_pkg::sq_side_t side_next;

  always_comb begin
    if (trace > 0)           br = r2q_pkg::BR_TRACE;
    else if (gt_01 && gt_02) br = r2q_pkg::BR_X;
    else if (gt_12)          br = r2q_pkg::BR_Y;
    else                     br = r2q_pkg::BR_Z;

    case (br)
      r2q_pkg::BR_TRACE: begin
        arg = arg_c[0]; d_sel[0] = d21m12; d_sel[1] = d02m20; d_sel[2] = d10m01;
      end
      r2q_pkg::BR_X: begin
        arg = arg_c[1]; d_sel[0] = d21m12; d_sel[1] = s01p10; d_sel[2] = s02p20;
      end
      r2q_pkg::BR_Y: begin
        arg = arg_c[2]; d_sel[0] = d02m20; d_sel[1] = s01p10; d_sel[2] = s12p21;
      end
      default: begin
        arg = arg_c[3]; d_sel[0] = d10m01; d_sel[1] = s02p20; d_sel[2] = s12p21;
      end
    endcase

    bad              = arg <= 0;
    side_next.branch = br;
    side_next.bad    = bad;
    for (int k = 0; k < r2q_pkg::LANES; k++) begin
      side_next.d_neg[k] = d_sel[k][r2q_pkg::ARG_W-1];
      side_next.d_mag[k] = d_sel[k][r2q_pkg::ARG_W-1] ?
                           r2q_pkg::MAG_W'(-d_sel[k]) : r2q_pkg::MAG_W'(d_sel[k]);
    end
  end

  always_ff @(posedge clk) begin
    side    <= side_next;
    arg_mag <= bad ? '0 : arg[r2q_pkg::ARG_MAG_W-1:0];
  end

endmodule

[rtl/r2q_sqrt.sv]
// ----------------------------------------------------------------------------
// r2q_sqrt
// Pipelined digit-by-digit integer square root of arg << FRAC_BITS,
// one root bit per stage.
// ----------------------------------------------------------------------------
module r2q_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [r2q_pkg::ARG_MAG_W-1:0]  arg_mag,
  input  r2q_pkg::sq_side_t              in_side,
  output logic                           out_valid,
  output logic [r2q_pkg::ROOT_W-1:0]     root,
  output r2q_pkg::sq_side_t              out_side
);

  logic                          vld  [0:r2q_pkg::ROOT_W];
  logic [r2q_pkg::SQ_IN_W-1:0]   rad  [0:r2q_pkg::ROOT_W];
  logic [r2q_pkg::REM_W-1:0]     rem  [0:r2q_pkg::ROOT_W];
  logic [r2q_pkg::ROOT_W-1:0]    rt   [0:r2q_pkg::ROOT_W];
  r2q_pkg::sq_side_t             sd   [0:r2q_pkg::ROOT_W];

  assign vld[0] = in_valid;
  assign rad[0] = r2q_pkg::SQ_IN_W'(arg_mag) << r2q_pkg::FRAC_BITS;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < r2q_pkg::ROOT_W; i++) begin : g_step
    logic [r2q_pkg::REM_W-1:0] cur;
    logic [r2q_pkg::REM_W-1:0] trial;
    logic                      ge;

    always_comb begin
      cur   = {rem[i][r2q_pkg::ROOT_W-1:0], rad[i][r2q_pkg::SQ_IN_W-1 -: 2]};
      trial = {rt[i], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk) begin
      rad[i+1] <= rad[i] << 2;
      rem[i+1] <= ge ? cur - trial : cur;
      rt[i+1]  <= {rt[i][r2q_pkg::ROOT_W-2:0], ge};
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[r2q_pkg::ROOT_W];
  assign root      = rt[r2q_pkg::ROOT_W];
  assign out_side  = sd[r2q_pkg::ROOT_W];

endmodule

[rtl/r2q_div.sv]
// ----------------------------------------------------------------------------
// r2q_div
// Three pipelined restoring dividers, one quotient bit per stage, forming
// (|D| << FRAC_BITS + R) / (2R) for the off-diagonal components.
// ----------------------------------------------------------------------------
module r2q_div (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  input  logic [r2q_pkg::ROOT_W-1:0]                    root,
  input  r2q_pkg::sq_side_t                             in_side,
  output logic                                          out_valid,
  output logic [r2q_pkg::LANES-1:0][r2q_pkg::Q_W-1:0]   quot,
  output r2q_pkg::div_side_t                            out_side
);

  localparam int STEPS = r2q_pkg::NUM_W;

  logic                                            vld [0:STEPS];
  logic [r2q_pkg::DEN_W-1:0]                       den [0:STEPS];
  logic [r2q_pkg::LANES-1:0][r2q_pkg::NUM_W-1:0]   nq  [0:STEPS];
  logic [r2q_pkg::LANES-1:0][r2q_pkg::DEN_W-1:0]   pr  [0:STEPS];
  r2q_pkg::div_side_t                              sd  [0:STEPS];

  // Entry stage: build numerators, denominator and the branch component.
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    den[0]       <= {root, 1'b0};
    sd[0].branch <= in_side.branch;
    sd[0].bad    <= in_side.bad;
    sd[0].d_neg  <= in_side.d_neg;
    sd[0].diag   <= r2q_pkg::ROOT_W'(({1'b0, root} + 1'b1) >> 1);
    for (int k = 0; k < r2q_pkg::LANES; k++) begin
      nq[0][k] <= (r2q_pkg::NUM_W'(in_side.d_mag[k]) << r2q_pkg::FRAC_BITS)
                  + r2q_pkg::NUM_W'(root);
      pr[0][k] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [r2q_pkg::LANES-1:0][r2q_pkg::DEN_W:0]     cur;
    logic [r2q_pkg::LANES-1:0]                       ge;
    logic [r2q_pkg::LANES-1:0][r2q_pkg::DEN_W-1:0]   pr_next;
    logic [r2q_pkg::LANES-1:0][r2q_pkg::NUM_W-1:0]   nq_next;

    always_comb begin
      for (int k = 0; k < r2q_pkg::LANES; k++) begin
        cur[k]     = {pr[i][k], nq[i][k][r2q_pkg::NUM_W-1]};
        ge[k]      = cur[k] >= {1'b0, den[i]};
        pr_next[k] = ge[k] ? r2q_pkg::DEN_W'(cur[k] - {1'b0, den[i]})
                           : r2q_pkg::DEN_W'(cur[k]);
        nq_next[k] = {nq[i][k][r2q_pkg::NUM_W-2:0], ge[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk) begin
      den[i+1] <= den[i];
      pr[i+1]  <= pr_next;
      nq[i+1]  <= nq_next;
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[STEPS];
  assign quot      = nq[STEPS];
  assign out_side  = sd[STEPS];

endmodule
